FILE: design/afwm_pkg.sv
package afwm_pkg;

  typedef logic [1:0] axis_t;

  // Opcode of the input word
  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_XFORM = 1'b1;

  // pi/2 in unsigned Q30
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] ONE_Q30     = 32'd1073741824;

  // Divisors of the Horner steps of the sine series, innermost first
  localparam logic [7:0] SERIES_DIV [0:5] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

  // Same divisions as reciprocal multiplies, exact for any 32-bit dividend:
  // floor(n / d) = ((n >> RCP_PRE) * RCP_MUL) >> RCP_POST
  localparam logic [1:0]  RCP_PRE  [0:5] = '{2'd2, 2'd1, 2'd3, 2'd1, 2'd2, 2'd1};
  localparam logic [31:0] RCP_MUL  [0:5] = '{
    32'd3524075731, 32'd2498890064, 32'd3817748708,
    32'd3272356036, 32'd3435973837, 32'd2863311531
  };
  localparam logic [5:0]  RCP_POST [0:5] = '{6'd37, 6'd37, 6'd35, 6'd36, 6'd34, 6'd33};

  // Axis order per rotation_order code; unused codes fall back to ZXY
  localparam axis_t ORDER_TAB [0:7][0:2] = '{
    '{2'd2, 2'd0, 2'd1}, '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd2},
    '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd0, 2'd1}
  };

  localparam logic [2:0] SER_LAST  = 3'd5;
  localparam logic [2:0] TRIG_LAST = 3'd5;
  localparam logic [1:0] IDX_LAST3 = 2'd2;
  localparam logic [1:0] IDX_LAST4 = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_XF_ISSUE, S_XF_DRAIN, S_XF_EMIT,
    S_TH_MUL, S_TH_LD, S_X2_MUL, S_X2_LD,
    S_SER_MUL, S_DIV_LD, S_DIV, S_SER_T,
    S_SIN_MUL, S_SIN_LD,
    S_P_ISSUE, S_P_DRAIN, S_R_ISSUE, S_R_DRAIN,
    S_W_ISSUE, S_W_DRAIN, S_EMIT
  } ctl_state_t;

  typedef enum logic [3:0] {
    MOP_ROT1, MOP_ROT2, MOP_WORLD, MOP_XFORM,
    MOP_THETA, MOP_X2, MOP_SERIES, MOP_SINE, MOP_RECIP
  } mul_op_t;

  typedef enum logic [1:0] {
    DST_P, DST_R, DST_W, DST_VEC
  } dest_t;

  typedef struct packed {
    logic       ld_in;
    mul_op_t    mul_op;
    logic       issue;
    logic       first;
    logic       last;
    dest_t      dest;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
    logic [2:0] trig_sel;
    logic [2:0] ser;
    logic       ld_theta;
    logic       ld_x2;
    logic       t_init;
    logic       div_load;
    logic       ld_t;
    logic       ld_trig;
    logic       emit;
    logic       emit_vec;
    logic       emit_last;
  } dp_cmd_t;

endpackage

FILE: design/affine_world_matrix_transform.sv
// Affine world-matrix unit, row-vector convention, signed fixed point.
// Input channel (in_valid / in_stall): one word per command. command 0
// builds W = S * R * T from scale, three angles and a translation, stores
// it and returns its four rows (row_index 0..3, last on row 3). command 1
// multiplies (x, y, z) by the stored upper 3x3 and returns one word with
// row_index 0, elem_3 zero and last set.
// Config channel (cfg_valid / cfg_ready): rotation_order, always ready;
// write it only while the unit is idle.
// Output channel (out_valid / out_stall): one output register; a stalled
// word holds until taken, and the sequencer waits there before the next.
// Datapath: one shared 33x33 multiplier with a two-stage accumulate/round
// pipeline. A transform is 9 multiply issues plus a pipeline drain before
// its word is registered; no new word is accepted until then.
// A build runs six sines (6-step Horner series, each divide done as a
// reciprocal multiply) then 27 + 27 + 16 issues, each group followed by a
// drain, then emits its rows; in_stall stays high until the last is registered.
// Synchronous reset loads the identity matrix and order code 0 (ZXY).
module affine_world_matrix_transform #(
  parameter int FRAC_BITS  = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic signed [31:0] value_x,
  input  logic signed [31:0] value_y,
  input  logic signed [31:0] value_z,
  input  logic [15:0]        angle_x,
  input  logic [15:0]        angle_y,
  input  logic [15:0]        angle_z,
  input  logic signed [31:0] move_x,
  input  logic signed [31:0] move_y,
  input  logic signed [31:0] move_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         row_index,
  output logic signed [31:0] elem_0,
  output logic signed [31:0] elem_1,
  output logic signed [31:0] elem_2,
  output logic signed [31:0] elem_3,
  output logic               last
);
  import afwm_pkg::*;

  dp_cmd_t cmd;

  // config register lives in the datapath; writes are never refused
  assign cfg_ready = 1'b1;

  afwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  afwm_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .value_x   (value_x),
    .value_y   (value_y),
    .value_z   (value_z),
    .angle_x   (angle_x),
    .angle_y   (angle_y),
    .angle_z   (angle_z),
    .move_x    (move_x),
    .move_y    (move_y),
    .move_z    (move_z),
    .row_index (row_index),
    .elem_0    (elem_0),
    .elem_1    (elem_1),
    .elem_2    (elem_2),
    .elem_3    (elem_3)
  );

  // last flag registered alongside the output word
  always_ff @(posedge clk) begin
    if (cmd.emit) last <= cmd.emit_last;
  end

endmodule

FILE: design/afwm_ctrl.sv
module afwm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  output logic              out_valid,
  input  logic              out_stall,
  output afwm_pkg::dp_cmd_t cmd
);
  import afwm_pkg::*;

  ctl_state_t state, state_next;
  logic [1:0] i, i_next, j, j_next, k, k_next;
  logic [2:0] ser, ser_next, n, n_next;
  logic [4:0] cnt, cnt_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      ser       <= '0;
      n         <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      i         <= i_next;
      j         <= j_next;
      k         <= k_next;
      ser       <= ser_next;
      n         <= n_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    ser_next   = ser;
    n_next     = n;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_op = MOP_XFORM;
    cmd.dest   = DST_VEC;
    cmd.i      = i;
    cmd.j      = j;
    cmd.k      = k;
    cmd.ser    = ser;
    cmd.trig_sel = n;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          i_next = '0;
          j_next = '0;
          k_next = '0;
          n_next = '0;
          state_next = (command == CMD_XFORM) ? S_XF_ISSUE : S_TH_MUL;
        end
      end
      S_XF_ISSUE: begin
        cmd.issue  = 1'b1;
        cmd.mul_op = MOP_XFORM;
        cmd.dest   = DST_VEC;
        cmd.first  = (k == 2'd0);
        cmd.last   = (k == IDX_LAST3);
        k_next = k + 2'd1;
        if (k == IDX_LAST3) begin
          k_next = '0;
          j_next = j + 2'd1;
          if (j == IDX_LAST3) begin
            j_next = '0;
            cnt_next = '0;
            state_next = S_XF_DRAIN;
          end
        end
      end
      S_XF_DRAIN: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd1) state_next = S_XF_EMIT;
      end
      S_XF_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_vec  = 1'b1;
          cmd.emit_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TH_MUL: begin
        cmd.mul_op = MOP_THETA;
        state_next = S_TH_LD;
      end
      S_TH_LD: begin
        cmd.ld_theta = 1'b1;
        state_next = S_X2_MUL;
      end
      S_X2_MUL: begin
        cmd.mul_op = MOP_X2;
        state_next = S_X2_LD;
      end
      S_X2_LD: begin
        cmd.ld_x2  = 1'b1;
        cmd.t_init = 1'b1;
        ser_next = '0;
        state_next = S_SER_MUL;
      end
      S_SER_MUL: begin
        cmd.mul_op = MOP_SERIES;
        state_next = S_DIV_LD;
      end
      S_DIV_LD: begin
        cmd.div_load = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.mul_op = MOP_RECIP;
        state_next = S_SER_T;
      end
      S_SER_T: begin
        cmd.ld_t = 1'b1;
        if (ser == SER_LAST) begin
          state_next = S_SIN_MUL;
        end else begin
          ser_next = ser + 3'd1;
          state_next = S_SER_MUL;
        end
      end
      S_SIN_MUL: begin
        cmd.mul_op = MOP_SINE;
        state_next = S_SIN_LD;
      end
      S_SIN_LD: begin
        cmd.ld_trig = 1'b1;
        if (n == TRIG_LAST) begin
          i_next = '0;
          j_next = '0;
          k_next = '0;
          state_next = S_P_ISSUE;
        end else begin
          n_next = n + 3'd1;
          state_next = S_TH_MUL;
        end
      end
      S_P_ISSUE, S_R_ISSUE: begin
        cmd.issue  = 1'b1;
        cmd.mul_op = (state == S_P_ISSUE) ? MOP_ROT1 : MOP_ROT2;
        cmd.dest   = (state == S_P_ISSUE) ? DST_P : DST_R;
        cmd.first  = (k == 2'd0);
        cmd.last   = (k == IDX_LAST3);
        k_next = k + 2'd1;
        if (k == IDX_LAST3) begin
          k_next = '0;
          j_next = j + 2'd1;
          if (j == IDX_LAST3) begin
            j_next = '0;
            i_next = i + 2'd1;
            if (i == IDX_LAST3) begin
              i_next = '0;
              cnt_next = '0;
              state_next = (state == S_P_ISSUE) ? S_P_DRAIN : S_R_DRAIN;
            end
          end
        end
      end
      S_P_DRAIN, S_R_DRAIN, S_W_DRAIN: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd1) begin
          case (state)
            S_P_DRAIN: state_next = S_R_ISSUE;
            S_R_DRAIN: state_next = S_W_ISSUE;
            default:   state_next = S_EMIT;
          endcase
        end
      end
      S_W_ISSUE: begin
        cmd.issue  = 1'b1;
        cmd.mul_op = MOP_WORLD;
        cmd.dest   = DST_W;
        cmd.first  = 1'b1;
        cmd.last   = 1'b1;
        j_next = j + 2'd1;
        if (j == IDX_LAST4) begin
          i_next = i + 2'd1;
          if (i == IDX_LAST4) begin
            cnt_next = '0;
            state_next = S_W_DRAIN;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = (i == IDX_LAST4);
          i_next = i + 2'd1;
          if (i == IDX_LAST4) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) out_valid_next = 1'b1;
    else if (out_stall) out_valid_next = out_valid;
    else out_valid_next = 1'b0;
  end

endmodule

FILE: design/afwm_datapath.sv
module afwm_datapath #(
  parameter int FRAC_BITS  = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  afwm_pkg::dp_cmd_t  cmd,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_data,
  input  logic signed [31:0] value_x,
  input  logic signed [31:0] value_y,
  input  logic signed [31:0] value_z,
  input  logic [15:0]        angle_x,
  input  logic [15:0]        angle_y,
  input  logic [15:0]        angle_z,
  input  logic signed [31:0] move_x,
  input  logic signed [31:0] move_y,
  input  logic signed [31:0] move_z,
  output logic [1:0]         row_index,
  output logic signed [31:0] elem_0,
  output logic signed [31:0] elem_1,
  output logic signed [31:0] elem_2,
  output logic signed [31:0] elem_3
);
  import afwm_pkg::*;

  localparam int QTR_BITS = ANGLE_BITS - 2;
  localparam logic signed [31:0] ONE_FIX = 32'sd1 <<< FRAC_BITS;
  localparam logic [ANGLE_BITS-1:0] QTR_TURN = {2'b01, {QTR_BITS{1'b0}}};
  localparam logic [QTR_BITS:0] QTR_FULL = {1'b1, {QTR_BITS{1'b0}}};
  localparam logic [65:0] THETA_HALF = 66'd1 << (QTR_BITS - 1);
  localparam logic [32:0] SIN_HALF = 33'd1 << (29 - FRAC_BITS);
  localparam logic signed [65:0] RND_HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483647 - 66'sd1;

  function automatic logic signed [31:0] rot_elem(input axis_t ax, input logic [1:0] ri,
                                                 input logic [1:0] ci,
                                                 input logic signed [31:0] sv,
                                                 input logic signed [31:0] cv);
    logic [1:0] b;
    logic [1:0] d;
    logic signed [31:0] e;
    b = (ax == 2'd0) ? 2'd1 : 2'd0;
    d = (ax == 2'd2) ? 2'd1 : 2'd2;
    e = '0;
    if (ri == ax && ci == ax) e = ONE_FIX;
    else if ((ri == b && ci == b) || (ri == d && ci == d)) e = cv;
    else if (ax == 2'd1) begin
      if (ri == 2'd0 && ci == 2'd2) e = -sv;
      else if (ri == 2'd2 && ci == 2'd0) e = sv;
    end else begin
      if (ri == b && ci == d) e = sv;
      else if (ri == d && ci == b) e = -sv;
    end
    return e;
  endfunction

  // configuration and latched input word
  logic [2:0]               rot_order;
  logic signed [31:0]       vin [3];
  logic signed [31:0]       mv [3];
  logic [ANGLE_BITS-1:0]    ang [3];

  // sine evaluation
  logic [31:0]  theta, x2, quo, quo_rcp;
  logic [30:0]  t;
  logic signed [31:0] trig_s [3];
  logic signed [31:0] trig_c [3];

  // matrices
  logic signed [31:0] pm [9];
  logic signed [31:0] rm [9];
  logic signed [31:0] wm [4][4];
  logic signed [31:0] vec [3];

  // multiply / accumulate / round pipeline
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod, acc;
  logic               p_valid, p_first, p_last, a_valid;
  dest_t              p_dest, a_dest;
  logic [1:0]         p_i, p_j, a_i, a_j;

  axis_t ord0, ord1, ord2, trig_axis;
  logic [1:0] slot;
  logic [ANGLE_BITS-1:0] ang_sel;
  logic [1:0] quad;
  logic [QTR_BITS:0] r;
  logic [3:0] pidx, ridx;
  logic [1:0] vidx, wrow;
  logic signed [31:0] v_rd, res;
  logic signed [65:0] rnd;
  logic [32:0] s_rnd, s_sh;
  logic signed [31:0] s_val;
  logic [31:0] t_diff;

  assign ord0 = ORDER_TAB[rot_order][0];
  assign ord1 = ORDER_TAB[rot_order][1];
  assign ord2 = ORDER_TAB[rot_order][2];

  // angle reduction to a quarter wave
  always_comb begin
    slot = cmd.trig_sel[2:1];
    case (slot)
      2'd0:    trig_axis = ord0;
      2'd1:    trig_axis = ord1;
      default: trig_axis = ord2;
    endcase
    ang_sel = ang[trig_axis];
    if (cmd.trig_sel[0]) ang_sel = ang_sel + QTR_TURN;
    quad = ang_sel[ANGLE_BITS-1:ANGLE_BITS-2];
    r = {1'b0, ang_sel[QTR_BITS-1:0]};
    if (quad[0]) r = QTR_FULL - r;
  end

  always_comb begin
    pidx = ({2'b00, cmd.i} << 1) + {2'b00, cmd.i} + {2'b00, cmd.k};
    ridx = ({2'b00, cmd.i} << 1) + {2'b00, cmd.i} + {2'b00, cmd.j};
    vidx = (cmd.mul_op == MOP_XFORM) ? cmd.k : cmd.i;
    wrow = cmd.emit ? cmd.i : cmd.k;
    v_rd = vin[vidx];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MOP_ROT1: begin
        mul_a = 33'(rot_elem(ord0, cmd.i, cmd.k, trig_s[0], trig_c[0]));
        mul_b = 33'(rot_elem(ord1, cmd.k, cmd.j, trig_s[1], trig_c[1]));
      end
      MOP_ROT2: begin
        mul_a = 33'(pm[pidx]);
        mul_b = 33'(rot_elem(ord2, cmd.k, cmd.j, trig_s[2], trig_c[2]));
      end
      MOP_WORLD: begin
        if (cmd.i == IDX_LAST4) begin
          mul_a = (cmd.j == IDX_LAST4) ? 33'(ONE_FIX) : 33'(mv[cmd.j]);
          mul_b = 33'(ONE_FIX);
        end else begin
          mul_a = 33'(v_rd);
          mul_b = (cmd.j == IDX_LAST4) ? 33'sd0 : 33'(rm[ridx]);
        end
      end
      MOP_XFORM: begin
        mul_a = 33'(v_rd);
        mul_b = 33'(wm[wrow][cmd.j]);
      end
      MOP_THETA: begin
        mul_a = $signed({1'b0, 32'(r)});
        mul_b = $signed({2'b00, HALF_PI_Q30});
      end
      MOP_X2: begin
        mul_a = $signed({1'b0, theta});
        mul_b = $signed({1'b0, theta});
      end
      MOP_SERIES: begin
        mul_a = $signed({1'b0, x2});
        mul_b = $signed({2'b00, t});
      end
      MOP_SINE: begin
        mul_a = $signed({1'b0, theta});
        mul_b = $signed({2'b00, t});
      end
      MOP_RECIP: begin
        mul_a = $signed({1'b0, quo >> RCP_PRE[cmd.ser]});
        mul_b = $signed({1'b0, RCP_MUL[cmd.ser]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round half up, floor, saturate
  always_comb begin
    rnd = (acc + RND_HALF) >>> FRAC_BITS;
    if (rnd > SAT_MAX) res = 32'sh7fffffff;
    else if (rnd < SAT_MIN) res = 32'sh80000000;
    else res = rnd[31:0];
  end

  // sine result: Q30 down to FRAC_BITS, clamp to one, apply quadrant sign
  always_comb begin
    s_rnd = {1'b0, prod[61:30]} + SIN_HALF;
    s_sh  = s_rnd >> (30 - FRAC_BITS);
    if (s_sh > 33'(ONE_FIX)) s_val = ONE_FIX;
    else s_val = s_sh[31:0];
    if (quad[1]) s_val = -s_val;
  end

  // quotient of the series step from the reciprocal product
  assign quo_rcp = 32'($unsigned(prod) >> RCP_POST[cmd.ser]);
  assign t_diff  = ONE_Q30 - quo_rcp;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_order <= '0;
      p_valid   <= 1'b0;
      a_valid   <= 1'b0;
      for (int ri = 0; ri < 4; ri++) begin
        for (int ci = 0; ci < 4; ci++) begin
          wm[ri][ci] <= (ri == ci) ? ONE_FIX : 32'sd0;
        end
      end
    end else begin
      if (cfg_valid) rot_order <= cfg_data;
      p_valid <= cmd.issue;
      a_valid <= p_valid && p_last;
      if (a_valid && a_dest == DST_W) wm[a_i][a_j] <= res;
    end

    if (cmd.ld_in) begin
      vin[0] <= value_x;
      vin[1] <= value_y;
      vin[2] <= value_z;
      mv[0]  <= move_x;
      mv[1]  <= move_y;
      mv[2]  <= move_z;
      ang[0] <= ANGLE_BITS'(angle_x);
      ang[1] <= ANGLE_BITS'(angle_y);
      ang[2] <= ANGLE_BITS'(angle_z);
    end

    prod    <= mul_a * mul_b;
    p_first <= cmd.first;
    p_last  <= cmd.last;
    p_dest  <= cmd.dest;
    p_i     <= cmd.i;
    p_j     <= cmd.j;

    if (p_valid) acc <= p_first ? prod : acc + prod;
    a_dest <= p_dest;
    a_i    <= p_i;
    a_j    <= p_j;

    if (a_valid) begin
      case (a_dest)
        DST_P:   pm[({2'b00, a_i} << 1) + {2'b00, a_i} + {2'b00, a_j}] <= res;
        DST_R:   rm[({2'b00, a_i} << 1) + {2'b00, a_i} + {2'b00, a_j}] <= res;
        DST_VEC: vec[a_j] <= res;
        default: ;
      endcase
    end

    if (cmd.ld_theta) theta <= 32'(($unsigned(prod) + THETA_HALF) >> QTR_BITS);
    if (cmd.ld_x2) x2 <= prod[61:30];
    if (cmd.t_init) t <= ONE_Q30[30:0];
    if (cmd.div_load) quo <= prod[61:30];
    if (cmd.ld_t) t <= t_diff[30:0];
    if (cmd.ld_trig) begin
      if (cmd.trig_sel[0]) trig_c[slot] <= s_val;
      else trig_s[slot] <= s_val;
    end

    if (cmd.emit) begin
      if (cmd.emit_vec) begin
        row_index <= '0;
        elem_0 <= vec[0];
        elem_1 <= vec[1];
        elem_2 <= vec[2];
        elem_3 <= '0;
      end else begin
        row_index <= cmd.i;
        elem_0 <= wm[wrow][0];
        elem_1 <= wm[wrow][1];
        elem_2 <= wm[wrow][2];
        elem_3 <= wm[wrow][3];
      end
    end
  end

endmodule

FILE: bench/tb_affine_world_matrix_transform.sv
`timescale 1ns / 100ps

module tb_affine_world_matrix_transform;
  import afwm_pkg::*;

  // Result word as seen on the output channel
  typedef struct {
    logic [1:0]         row_index;
    logic signed [31:0] elem [4];
    logic               last;
  } row_word_t;

  typedef logic signed [31:0] fix_t;
  typedef fix_t mat3_t [3][3];

  localparam int         MAX_CYCLES = 4000000;
  localparam fix_t       ONE_FIX    = 32'sd65536;
  localparam logic [2:0] ORD_ZXY    = 3'd0;
  localparam logic [2:0] ORD_XZY    = 3'd2;
  localparam logic [2:0] ORD_YXZ    = 3'd3;
  localparam logic [2:0] ORD_ZYX    = 3'd5;
  localparam logic [2:0] ORD_SPARE  = 3'd7;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               command = CMD_BUILD;
  logic signed [31:0] value_x = '0, value_y = '0, value_z = '0;
  logic [15:0]        angle_x = '0, angle_y = '0, angle_z = '0;
  logic signed [31:0] move_x = '0, move_y = '0, move_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         row_index;
  logic signed [31:0] elem_0, elem_1, elem_2, elem_3;
  logic               last;

  // Predictor state: stored world matrix and axis order
  fix_t       world [16];
  logic [2:0] axis_order;
  row_word_t  pending_rows [$];

  int         mismatches = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_off_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  affine_world_matrix_transform i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .value_x(value_x), .value_y(value_y), .value_z(value_z),
    .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
    .move_x(move_x), .move_y(move_y), .move_z(move_z),
    .out_valid(out_valid), .out_stall(out_stall), .row_index(row_index),
    .elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3),
    .last(last)
  );

  // ---------------------------------------------------------------- predictor

  function automatic longint floor16(longint v);
    return v >>> 16;  // arithmetic shift floors
  endfunction

  function automatic fix_t sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return fix_t'(v);
  endfunction

  // Sum of three full products, rounded half up once, saturated
  function automatic fix_t dot3(fix_t a0, fix_t b0, fix_t a1, fix_t b1,
                                fix_t a2, fix_t b2);
    longint     p [3];
    longint     hi;
    logic [63:0] lo;
    hi = 0;
    lo = 0;
    p[0] = longint'(a0) * longint'(b0);
    p[1] = longint'(a1) * longint'(b1);
    p[2] = longint'(a2) * longint'(b2);
    for (int k = 0; k < 3; k++) begin
      hi += floor16(p[k]);
      lo += {48'd0, p[k][15:0]};
    end
    lo += 64'd32768;
    hi += longint'(lo >> 16);
    return sat32(hi);
  endfunction

  // Sine over a quarter wave, r / 2^14 quarter turns
  function automatic fix_t quarter_sine(logic [14:0] r);
    logic [63:0] theta, x2, t, s;
    theta = ({49'd0, r} * 64'd1686629713 + 64'd8192) >> 14;
    x2 = (theta * theta) >> 30;
    t = 64'd1 << 30;
    for (int k = 0; k < 6; k++)
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'(SERIES_DIV[k]);
    s = (theta * t) >> 30;
    s = (s + 64'd8192) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return fix_t'(s);
  endfunction

  function automatic fix_t sine_of_turn(logic [15:0] a);
    logic [1:0]  quad;
    logic [14:0] r;
    fix_t        v;
    quad = a[15:14];
    r = {1'b0, a[13:0]};
    if (quad[0]) r = 15'd16384 - r;
    v = quarter_sine(r);
    return quad[1] ? -v : v;
  endfunction

  function automatic mat3_t axis_rotation(int axis, logic [15:0] angle);
    mat3_t m;
    fix_t  s, c;
    int    b, d;
    s = sine_of_turn(angle);
    c = sine_of_turn(angle + 16'd16384);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = 0;
    b = (axis == 0) ? 1 : 0;
    d = (axis == 2) ? 1 : 2;
    m[axis][axis] = ONE_FIX;
    m[b][b] = c;
    m[d][d] = c;
    if (axis == 1) begin
      m[0][2] = -s;
      m[2][0] = s;
    end else begin
      m[b][d] = s;
      m[d][b] = -s;
    end
    return m;
  endfunction

  function automatic mat3_t mul3(mat3_t a, mat3_t b);
    mat3_t o;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        o[i][j] = dot3(a[i][0], b[0][j], a[i][1], b[1][j], a[i][2], b[2][j]);
    return o;
  endfunction

  // Update the stored matrix for one command and queue the rows it emits
  task automatic predict_rows(logic cmd, fix_t vx, fix_t vy, fix_t vz,
                              logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                              fix_t mx, fix_t my, fix_t mz);
    fix_t       v [3];
    mat3_t      rot [3];
    mat3_t      r;
    row_word_t  w;
    logic [15:0] ang [3];
    v = '{vx, vy, vz};
    if (cmd == CMD_XFORM) begin
      for (int j = 0; j < 3; j++)
        w.elem[j] = dot3(v[0], world[j], v[1], world[4 + j], v[2], world[8 + j]);
      w.elem[3] = 0;
      w.row_index = 2'd0;
      w.last = 1'b1;
      pending_rows.push_back(w);
    end else begin
      ang = '{ax, ay, az};
      for (int i = 0; i < 3; i++) rot[i] = axis_rotation(i, ang[i]);
      r = mul3(rot[ORDER_TAB[axis_order][0]], rot[ORDER_TAB[axis_order][1]]);
      r = mul3(r, rot[ORDER_TAB[axis_order][2]]);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) world[i * 4 + j] = dot3(v[i], r[i][j], 0, 0, 0, 0);
        world[i * 4 + 3] = 0;
      end
      world[12] = mx;
      world[13] = my;
      world[14] = mz;
      world[15] = ONE_FIX;
      for (int i = 0; i < 4; i++) begin
        w.row_index = 2'(i);
        for (int j = 0; j < 4; j++) w.elem[j] = world[i * 4 + j];
        w.last = (i == 3);
        pending_rows.push_back(w);
      end
    end
  endtask

  // ---------------------------------------------------------------- drivers

  // Offer one word, with random idle gaps before it, until accepted
  task automatic send_word(logic cmd, fix_t vx, fix_t vy, fix_t vz,
                           logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                           fix_t mx, fix_t my, fix_t mz);
    do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    command <= cmd;
    value_x <= vx; value_y <= vy; value_z <= vz;
    angle_x <= ax; angle_y <= ay; angle_z <= az;
    move_x <= mx; move_y <= my; move_z <= mz;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_rows(cmd, vx, vy, vz, ax, ay, az, mx, my, mz);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Register write; only called with the unit drained
  task automatic write_order(logic [2:0] code);
    wait_drained();
    cfg_data <= code;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    axis_order = code;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic fix_t rand_fix();
    case ($urandom_range(5))
      0: return fix_t'($urandom);
      1: return fix_t'($urandom_range(131072)) - 65536;     // within +-1.0
      2: return fix_t'($urandom_range(2097152)) - 1048576;  // within +-16
      3: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return fix_t'($urandom_range(33554432)) - 16777216;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'($urandom_range(3)) << 14;  // exact quarter turns
      1: return (16'($urandom_range(3)) << 14) + 16'($urandom_range(2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int build_pct);
    logic cmd;
    cmd = ($urandom_range(99) < build_pct) ? CMD_BUILD : CMD_XFORM;
    send_word(cmd, rand_fix(), rand_fix(), rand_fix(), rand_angle(),
              rand_angle(), rand_angle(), rand_fix(), rand_fix(), rand_fix());
  endtask

  // ---------------------------------------------------------------- checker

  // Random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    row_word_t exp_w;
    logic signed [31:0] got [4];
    logic bad;
    if (!rst && out_valid && !out_stall) begin
      got = '{elem_0, elem_1, elem_2, elem_3};
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: row %0d", row_index);
      end else begin
        exp_w = pending_rows.pop_front();
        bad = (row_index !== exp_w.row_index) || (last !== exp_w.last);
        for (int j = 0; j < 4; j++) bad |= (got[j] !== exp_w.elem[j]);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp row %0d %h %h %h %h last %b, got row %0d %h %h %h %h last %b",
                     exp_w.row_index, exp_w.elem[0], exp_w.elem[1], exp_w.elem[2],
                     exp_w.elem[3], exp_w.last, row_index, got[0], got[1], got[2],
                     got[3], last);
        end
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("affine_world_matrix_transform test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    fix_t minv, maxv;
    minv = 32'sh80000000;
    maxv = 32'sh7fffffff;
    // transform before any build sees the identity
    send_word(CMD_XFORM, maxv, minv, 32'sd65536, 0, 0, 0, 0, 0, 0);
    send_word(CMD_XFORM, -1, 1, 0, 16'hffff, 16'hffff, 16'hffff, -1, -1, -1);
    // zero angles, unit scale
    send_word(CMD_BUILD, ONE_FIX, ONE_FIX, ONE_FIX, 0, 0, 0, maxv, minv, 0);
    send_word(CMD_XFORM, 32'sd196608, -32'sd65536, 32'sd12345, 0, 0, 0, 0, 0, 0);
    // quarter turns and extreme scales saturate
    send_word(CMD_BUILD, maxv, minv, maxv, 16'h4000, 16'h8000, 16'hc000, minv, maxv, -1);
    send_word(CMD_XFORM, maxv, maxv, maxv, 0, 0, 0, 0, 0, 0);
    send_word(CMD_XFORM, minv, minv, minv, 0, 0, 0, 0, 0, 0);
    send_word(CMD_BUILD, -ONE_FIX, 32'sd32768, 32'sd131072, 16'hffff, 16'h3fff,
              16'h0001, 32'sd1, -32'sd1, 32'sd65536);
    send_word(CMD_XFORM, ONE_FIX, ONE_FIX, ONE_FIX, 0, 0, 0, 0, 0, 0);
    // every order code, including the spare ones that act as ZXY
    for (int o = 0; o < 8; o++) begin
      write_order(3'(o));
      send_word(CMD_BUILD, ONE_FIX, ONE_FIX, ONE_FIX, 16'h1234, 16'h5678, 16'h9abc,
                0, 0, 0);
      send_word(CMD_XFORM, 32'sd65536, 32'sd131072, -32'sd196608, 0, 0, 0, 0, 0, 0);
    end
    write_order(ORD_SPARE);
  endtask

  // Mostly transforms, a build now and then; idling as the phase sets
  task automatic test_random_phase(int idle, int stall, int count, logic [2:0] code);
    write_order(code);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    send_random(0);  // a transform first
    for (int n = 1; n < count; n++) send_random(8);
  endtask

  // Long receiver hold-off while the sender keeps offering words
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 600;
    for (int n = 0; n < 20; n++) send_random(0);
    // pause until everything is back, then go on
    while (pending_rows.size() != 0) @(negedge clk);
    for (int n = 0; n < 10; n++) send_random(20);
  endtask

  initial begin
    for (int i = 0; i < 16; i++) world[i] = (i % 5 == 0) ? ONE_FIX : 0;
    axis_order = ORD_ZXY;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phase(0, 0, 100, ORD_ZXY);
    test_random_phase(62, 0, 90, ORD_ZYX);
    test_random_phase(0, 62, 90, ORD_XZY);
    test_random_phase(31, 31, 80, ORD_YXZ);
    test_backpressure();
    wait_drained();
    if (mismatches == 0 && pending_rows.size() == 0)
      $display("affine_world_matrix_transform test passed");
    else
      $display("affine_world_matrix_transform test failed");
    $finish;
  end

endmodule
